/* src/bwfc_pkg.sv */
// ----------------------------------------------------------------------------
// bwfc_pkg
// Shared types and codes of the bob/weave field composer.
// ----------------------------------------------------------------------------
package bwfc_pkg;

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_BLANK  = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  // Field widths fixed by the stream format
  localparam int unsigned WidthW  = 10;
  localparam int unsigned HeightW = 9;
  localparam int unsigned ParityW = 2;
  localparam int unsigned PixW    = 32;
  localparam int unsigned CoordW  = 10;
  localparam int unsigned OffW    = WidthW + HeightW;
  // Wide enough for a size limit of up to 8191
  localparam int unsigned LimitW  = 13;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 72;

  // Result list of one accepted beat, handed from decode to the sequencer
  typedef struct packed {
    logic [1:0]         wr_cnt;    // pixel writes: 0, 1 (pass) or 2 (bob/weave)
    logic               weave;     // second word comes from the stored field
    logic               par;       // parity of the current field
    logic               tail;      // closing result follows the writes
    kind_e              tail_kind;
    logic [WidthW-1:0]  x;
    logic [HeightW-1:0] row;
    logic [WidthW-1:0]  fw;
    logic [CoordW-1:0]  fh_frame;  // frame height, doubled when interlaced
    logic [PixW-1:0]    pix;
  } job_t;

endpackage

/* src/bwfc_field_store.sv */
// ----------------------------------------------------------------------------
// bwfc_field_store
// Two-bank field memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bwfc_field_store #(
  parameter int unsigned DEPTH  = 614400,
  parameter int unsigned ADDR_W = 20,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // Write the new field, read the stored one
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/bwfc_field_ctrl.sv */
// ----------------------------------------------------------------------------
// bwfc_field_ctrl
// Header check, field position counters, stored-field state and the
// result list of each accepted beat.
// ----------------------------------------------------------------------------
module bwfc_field_ctrl #(
  parameter int unsigned MAX_WIDTH  = 640,
  parameter int unsigned MAX_HEIGHT = 480,
  parameter int unsigned ADDR_W     = 20,
  parameter int unsigned STORE_W    = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // accepted beat
  input  logic                         accept_i,
  input  logic                         action_i,
  input  logic [bwfc_pkg::WidthW-1:0]  fw_i,
  input  logic [bwfc_pkg::HeightW-1:0] fh_i,
  input  logic [bwfc_pkg::ParityW-1:0] par_i,
  input  logic                         il_i,
  input  logic [bwfc_pkg::PixW-1:0]    pix_i,
  input  logic                         last_i,
  // field memory
  output logic                         wr_en_o,
  output logic [ADDR_W-1:0]            wr_addr_o,
  output logic [STORE_W-1:0]           wr_data_o,
  output logic                         rd_en_o,
  output logic [ADDR_W-1:0]            rd_addr_o,
  // result list
  output logic                         job_load_o,
  output bwfc_pkg::job_t               job_o
);

  localparam int unsigned BankWords = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned WidthW    = bwfc_pkg::WidthW;
  localparam int unsigned HeightW   = bwfc_pkg::HeightW;
  localparam int unsigned OffW      = bwfc_pkg::OffW;
  localparam int unsigned LimitW    = bwfc_pkg::LimitW;

  // Stored field
  logic               s_bank_q, s_bank_d;
  logic               s_valid_q, s_valid_d;
  logic [WidthW-1:0]  s_width_q, s_width_d;
  logic [HeightW-1:0] s_height_q, s_height_d;
  logic               s_il_q, s_il_d;
  logic               s_par_q, s_par_d;
  // Field in progress
  logic [WidthW-1:0]  col_q, col_d;
  logic [HeightW-1:0] row_q, row_d;
  logic               in_field_q, in_field_d;
  logic               weave_q, weave_d;
  logic               ferr_q, ferr_d;

  logic               hdr_ok;
  logic [WidthW-1:0]  col;
  logic [HeightW-1:0] row;
  logic               ferr;
  logic               weave;
  logic               bad;
  logic               at_end;
  logic               field_ok;
  logic [WidthW-1:0]  col_inc;
  logic [OffW-1:0]    prod;
  logic [OffW-1:0]    off;
  logic [ADDR_W-1:0]  off_a;

  // Check the header against the size limits
  assign hdr_ok = (fw_i != '0) && (fh_i != '0) &&
                  ({{(LimitW-WidthW){1'b0}}, fw_i} <= LimitW'(MAX_WIDTH)) &&
                  ({{(LimitW-HeightW){1'b0}}, fh_i} <= LimitW'(MAX_HEIGHT)) &&
                  (par_i[1] == 1'b0);

  // Start a fresh field on its first beat
  assign col   = in_field_q ? col_q : '0;
  assign row   = in_field_q ? row_q : '0;
  assign ferr  = in_field_q ? ferr_q : 1'b0;
  assign weave = in_field_q ? weave_q :
                 (hdr_ok && il_i && s_valid_q && s_il_q &&
                  (s_width_q == fw_i) && (s_height_q == fh_i) &&
                  (s_par_q != par_i[0]));

  assign bad      = !hdr_ok || (col >= fw_i) || (row >= fh_i);
  assign at_end   = !bad && (col == fw_i - 1'b1) && (row == fh_i - 1'b1);
  assign field_ok = !(ferr || bad) && at_end;
  assign col_inc  = col + 1'b1;

  // Offset of the pixel within a bank
  assign prod  = OffW'(row) * OffW'(fw_i);
  assign off   = prod + OffW'(col);
  assign off_a = ADDR_W'(off);

  // Write the new field into the free bank, read the stored bank
  assign wr_en_o   = accept_i && !action_i && !bad && il_i;
  assign wr_addr_o = off_a + (s_bank_q ? '0 : ADDR_W'(BankWords));
  assign wr_data_o = pix_i[STORE_W-1:0];
  assign rd_en_o   = accept_i && !action_i;
  assign rd_addr_o = off_a + (s_bank_q ? ADDR_W'(BankWords) : '0);

  // Build the result list
  always_comb begin
    job_o           = '0;
    job_o.x         = col;
    job_o.row       = row;
    job_o.fw        = fw_i;
    job_o.fh_frame  = il_i ? {fh_i, 1'b0} : {1'b0, fh_i};
    job_o.pix       = pix_i;
    job_o.par       = par_i[0];
    job_o.weave     = weave;
    job_o.tail_kind = bwfc_pkg::KIND_REJECT;
    if (action_i) begin
      job_o.tail      = 1'b1;
      job_o.tail_kind = bwfc_pkg::KIND_BLANK;
    end else begin
      if (!bad) begin
        job_o.wr_cnt = il_i ? 2'd2 : 2'd1;
      end
      job_o.tail = last_i;
      if (field_ok) begin
        job_o.tail_kind = bwfc_pkg::KIND_DONE;
      end
    end
  end

  assign job_load_o = accept_i && (action_i || !bad || last_i);

  // Advance the field state
  always_comb begin
    s_bank_d   = s_bank_q;
    s_valid_d  = s_valid_q;
    s_width_d  = s_width_q;
    s_height_d = s_height_q;
    s_il_d     = s_il_q;
    s_par_d    = s_par_q;
    col_d      = col_q;
    row_d      = row_q;
    in_field_d = in_field_q;
    weave_d    = weave_q;
    ferr_d     = ferr_q;
    if (accept_i) begin
      if (action_i) begin
        s_valid_d  = 1'b0;
        in_field_d = 1'b0;
        col_d      = '0;
        row_d      = '0;
        weave_d    = 1'b0;
        ferr_d     = 1'b0;
      end else begin
        in_field_d = 1'b1;
        weave_d    = weave;
        col_d      = col;
        row_d      = row;
        ferr_d     = ferr || bad;
        if (!bad) begin
          if (col_inc == fw_i) begin
            col_d = '0;
            row_d = row + 1'b1;
          end else begin
            col_d = col_inc;
          end
        end
        if (last_i) begin
          if (field_ok) begin
            if (il_i) begin
              s_bank_d   = !s_bank_q;
              s_valid_d  = 1'b1;
              s_width_d  = fw_i;
              s_height_d = fh_i;
              s_il_d     = 1'b1;
              s_par_d    = par_i[0];
            end else begin
              s_valid_d = 1'b0;
            end
          end
          in_field_d = 1'b0;
          col_d      = '0;
          row_d      = '0;
          weave_d    = 1'b0;
          ferr_d     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_bank_q   <= 1'b0;
      s_valid_q  <= 1'b0;
      s_width_q  <= '0;
      s_height_q <= '0;
      s_il_q     <= 1'b0;
      s_par_q    <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      in_field_q <= 1'b0;
      weave_q    <= 1'b0;
      ferr_q     <= 1'b0;
    end else begin
      s_bank_q   <= s_bank_d;
      s_valid_q  <= s_valid_d;
      s_width_q  <= s_width_d;
      s_height_q <= s_height_d;
      s_il_q     <= s_il_d;
      s_par_q    <= s_par_d;
      col_q      <= col_d;
      row_q      <= row_d;
      in_field_q <= in_field_d;
      weave_q    <= weave_d;
      ferr_q     <= ferr_d;
    end
  end

endmodule

/* src/bwfc_result_seq.sv */
// ----------------------------------------------------------------------------
// bwfc_result_seq
// Holds the result list of one beat and plays it out, one result a cycle
// while the receiver does not stall, through the output register.
// ----------------------------------------------------------------------------
module bwfc_result_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_load_i,
  input  bwfc_pkg::job_t                 job_i,
  input  logic [bwfc_pkg::PixW-1:0]      old_pix_i,
  output logic                           slot_free_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [bwfc_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic [1:0]                     m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);

  localparam int unsigned CoordW = bwfc_pkg::CoordW;
  localparam int unsigned PixW   = bwfc_pkg::PixW;

  bwfc_pkg::job_t job_q, job_d;
  logic           job_valid_q, job_valid_d;
  logic [1:0]     step_q, step_d;

  logic                          tvalid_q;
  logic [bwfc_pkg::OutDataW-1:0] tdata_q;
  logic [1:0]                    tuser_q;
  logic                          tlast_q;

  logic                 out_free;
  logic                 load;
  logic [1:0]           total;
  logic                 is_last;
  logic                 is_wr;
  bwfc_pkg::kind_e      r_kind;
  logic [CoordW-1:0]    r_x, r_y, r_fw, r_fh;
  logic [PixW-1:0]      r_pix;

  assign out_free    = !tvalid_q || m_axis_tready_i;
  assign load        = job_valid_q && out_free;
  assign total       = job_q.wr_cnt + {1'b0, job_q.tail};
  assign is_last     = (step_q == total - 2'd1);
  assign is_wr       = (step_q < job_q.wr_cnt);
  assign slot_free_o = !job_valid_q || (load && is_last);

  // Select the result at the current step
  always_comb begin
    r_kind = job_q.tail_kind;
    r_x    = '0;
    r_y    = '0;
    r_fw   = '0;
    r_fh   = '0;
    r_pix  = '0;
    if (is_wr) begin
      r_kind = bwfc_pkg::KIND_PIXEL;
      r_x    = job_q.x;
      r_y    = (job_q.wr_cnt == 2'd2) ? {job_q.row, step_q[0]} : {1'b0, job_q.row};
      r_fw   = job_q.fw;
      r_fh   = job_q.fh_frame;
      r_pix  = (job_q.wr_cnt == 2'd2 && job_q.weave && (step_q[0] != job_q.par)) ?
               old_pix_i : job_q.pix;
    end else if (job_q.tail_kind == bwfc_pkg::KIND_DONE) begin
      r_fw = job_q.fw;
      r_fh = job_q.fh_frame;
    end
  end

  // Take a new list, or step through the held one
  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    step_d      = step_q;
    if (job_load_i) begin
      job_d       = job_i;
      job_valid_d = 1'b1;
      step_d      = '0;
    end else if (load) begin
      if (is_last) begin
        job_valid_d = 1'b0;
      end
      step_d = step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      job_valid_q <= job_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  // Output register: load a result or drop the taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (load) begin
      tvalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tdata_q <= {r_pix, r_fh, r_fw, r_y, r_x};
      tuser_q <= r_kind;
      tlast_q <= is_last;
    end
  end

  assign m_axis_tvalid_o = tvalid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;
  assign m_axis_tlast_o  = tlast_q;

endmodule

/* src/bob_weave_field_composer_top.sv */
// ----------------------------------------------------------------------------
// bob_weave_field_composer_top
// Turns a pixel stream of video fields into addressed frame-buffer writes.
// ----------------------------------------------------------------------------
// Input beats carry one pixel with its field header; tuser set marks a
// blank, which clears the stored field. tlast marks the field's last pixel.
// Each beat yields a run of results on the output channel, tlast on its
// final result: a progressive pixel gives one write, an interlaced pixel
// two (bob or weave, the weave word read from the stored field bank), and
// a last pixel adds a frame-complete or field-rejected result. A beat with
// a bad header or outside its field writes nothing but marks the field bad.
// The first result of a beat passes through the job register of the sequencer
// and then the output register after the beat is accepted. The results of a
// beat leave in turn through the single output register: one for a progressive
// pixel, two for an interlaced pixel, plus one on a last pixel.
// A new beat is taken in the cycle the previous beat's final result moves
// into the output register. When the receiver stalls, the held result and
// the pending run wait and tready drops once the run is queued.
// Reset clears the stored-field and position state; field memory contents
// are undefined after reset and need no clearing pass.
// ----------------------------------------------------------------------------
module bob_weave_field_composer_top #(
  parameter int unsigned MAX_WIDTH  = 640,
  parameter int unsigned MAX_HEIGHT = 480,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // field_width[9:0], field_height[18:10], field_parity[20:19],
  // interlaced[21], pixel_value[53:22], zero fill[55:54]
  input  logic [bwfc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // action[0]
  input  logic                          s_axis_tuser_i,
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // out_x[9:0], out_y[19:10], frame_width[29:20], frame_height[39:30],
  // out_pixel[71:40]
  output logic [bwfc_pkg::OutDataW-1:0] m_axis_tdata_o,
  // kind[1:0]
  output logic [1:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  localparam int unsigned StoreW = (PIXEL_BITS < bwfc_pkg::PixW) ? PIXEL_BITS : bwfc_pkg::PixW;
  localparam int unsigned Depth  = 2 * MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW  = $clog2(Depth);

  logic                 accept;
  logic                 slot_free;
  logic                 wr_en, rd_en;
  logic [AddrW-1:0]     wr_addr, rd_addr;
  logic [StoreW-1:0]    wr_data, rd_data;
  logic [bwfc_pkg::PixW-1:0] old_pix;
  logic [bwfc_pkg::PixW-1:0] pix_in;
  logic                 job_load;
  bwfc_pkg::job_t       job;

  assign s_axis_tready_o = slot_free;
  assign accept          = s_axis_tvalid_i && slot_free;
  assign old_pix         = bwfc_pkg::PixW'(rd_data);

  // Drop pixel bits above the pixel width
  assign pix_in = bwfc_pkg::PixW'(s_axis_tdata_i[22 +: StoreW]);

  bwfc_field_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (AddrW),
    .STORE_W    (StoreW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .action_i   (s_axis_tuser_i),
    .fw_i       (s_axis_tdata_i[9:0]),
    .fh_i       (s_axis_tdata_i[18:10]),
    .par_i      (s_axis_tdata_i[20:19]),
    .il_i       (s_axis_tdata_i[21]),
    .pix_i      (pix_in),
    .last_i     (s_axis_tlast_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .job_load_o (job_load),
    .job_o      (job)
  );

  bwfc_field_store #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW),
    .DATA_W (StoreW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bwfc_result_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_load_i      (job_load),
    .job_i           (job),
    .old_pix_i       (old_pix),
    .slot_free_o     (slot_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

/* src/bwfc_checker.sv */
// ----------------------------------------------------------------------------
// bwfc_checker
// Port-level checks on the result stream of the field composer.
// ----------------------------------------------------------------------------
module bwfc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [bwfc_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [1:0]                    m_axis_tuser_o,
  input logic                          m_axis_tlast_o
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // Blank and reject close their run with an empty payload
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == bwfc_pkg::KIND_BLANK ||
                        m_axis_tuser_o == bwfc_pkg::KIND_REJECT) |->
      m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("blank or reject with payload");

  // Frame complete closes its run and carries only the frame size
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == bwfc_pkg::KIND_DONE) |->
      m_axis_tlast_o && (m_axis_tdata_o[19:0] == '0) && (m_axis_tdata_o[71:40] == '0))
    else $error("frame complete malformed");

  // A pixel write lies inside its frame
  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == bwfc_pkg::KIND_PIXEL) |->
      (m_axis_tdata_o[9:0] < m_axis_tdata_o[29:20]) &&
      (m_axis_tdata_o[19:10] < m_axis_tdata_o[39:30]))
    else $error("pixel write outside frame");

endmodule

bind bob_weave_field_composer_top bwfc_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

/* bench/bwfc_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bwfc_tb_pkg
// Beat types and the frame-write scoreboard of the field composer bench. The
// scoreboard mirrors the stored field, the field position and both banks of
// the field memory, and turns each accepted pixel beat into the frame writes
// and closing results that the block must produce.
// ----------------------------------------------------------------------------
package bwfc_tb_pkg;

  localparam int MaxWidth  = 640;
  localparam int MaxHeight = 480;
  localparam int BankWords = MaxWidth * MaxHeight;

  // Ways a generated field departs from a clean raster
  typedef enum int {
    FLAW_NONE,
    FLAW_SHORT,
    FLAW_LONG,
    FLAW_BADHDR,
    FLAW_RESIZE,
    FLAW_BLANK
  } flaw_e;

  // One input beat, unpacked
  typedef struct packed {
    logic                         action;
    logic [bwfc_pkg::WidthW-1:0]  fw;
    logic [bwfc_pkg::HeightW-1:0] fh;
    logic [bwfc_pkg::ParityW-1:0] par;
    logic                         il;
    logic [bwfc_pkg::PixW-1:0]    pix;
    logic                         last;
  } pix_beat_t;

  // One output beat, unpacked
  typedef struct packed {
    bwfc_pkg::kind_e             kind;
    logic [bwfc_pkg::CoordW-1:0] x;
    logic [bwfc_pkg::CoordW-1:0] y;
    logic [bwfc_pkg::CoordW-1:0] fw;
    logic [bwfc_pkg::CoordW-1:0] fh;
    logic [bwfc_pkg::PixW-1:0]   pix;
    logic                        last;
  } frame_wr_t;

  class frame_scoreboard;
    // Stored field and position within the current field
    bit                           stored_bank, stored_valid, stored_il, stored_par;
    logic [bwfc_pkg::WidthW-1:0]  stored_w;
    logic [bwfc_pkg::HeightW-1:0] stored_h;
    logic [bwfc_pkg::WidthW-1:0]  col;
    logic [bwfc_pkg::HeightW-1:0] row;
    bit                           in_field, weave_mode, field_err;
    // Field memory, both banks; an entry exists once written
    logic [bwfc_pkg::PixW-1:0]    fstore [int];
    frame_wr_t                    frame_wr_q [$];
    int                           errors, n_checked, n_weave, n_done, n_reject;

    function new();
      stored_bank  = 0;
      stored_valid = 0;
      stored_il    = 0;
      stored_par   = 0;
      stored_w     = '0;
      stored_h     = '0;
      errors       = 0;
      n_checked    = 0;
      n_weave      = 0;
      n_done       = 0;
      n_reject     = 0;
      end_field();
    endfunction

    function void end_field();
      in_field   = 0;
      col        = '0;
      row        = '0;
      weave_mode = 0;
      field_err  = 0;
    endfunction

    function bit header_ok(pix_beat_t b);
      return b.fw != 0 && b.fh != 0 && int'(b.fw) <= MaxWidth &&
             int'(b.fh) <= MaxHeight && b.par <= 2'd1;
    endfunction

    function bit weave_match(pix_beat_t b);
      return header_ok(b) && b.il && stored_valid && stored_il &&
             stored_w == b.fw && stored_h == b.fh && stored_par != b.par[0];
    endfunction

    function int store_key(bit bank, logic [bwfc_pkg::WidthW-1:0] x,
                           logic [bwfc_pkg::HeightW-1:0] y,
                           logic [bwfc_pkg::WidthW-1:0] fw);
      return (bank ? BankWords : 0) + int'(y) * int'(fw) + int'(x);
    endfunction

    // True when this beat would make the block read a never-written word
    function bit reads_unwritten(pix_beat_t b);
      bit                           wv;
      logic [bwfc_pkg::WidthW-1:0]  c;
      logic [bwfc_pkg::HeightW-1:0] r;
      if (b.action || !b.il) return 0;
      wv = in_field ? weave_mode : weave_match(b);
      c  = in_field ? col : '0;
      r  = in_field ? row : '0;
      if (!wv || !header_ok(b) || c >= b.fw || r >= b.fh) return 0;
      return !fstore.exists(store_key(stored_bank, c, r, b.fw));
    endfunction

    function frame_wr_t wr(bwfc_pkg::kind_e k, logic [bwfc_pkg::CoordW-1:0] x,
                           logic [bwfc_pkg::CoordW-1:0] y,
                           logic [bwfc_pkg::CoordW-1:0] fw,
                           logic [bwfc_pkg::CoordW-1:0] fh,
                           logic [bwfc_pkg::PixW-1:0] p);
      frame_wr_t r;
      r.kind = k;
      r.x    = x;
      r.y    = y;
      r.fw   = fw;
      r.fh   = fh;
      r.pix  = p;
      r.last = 1'b0;
      return r;
    endfunction

    // Work out the results of one accepted beat and queue them
    function void note_beat(pix_beat_t b);
      frame_wr_t                    run [$];
      logic [bwfc_pkg::PixW-1:0]    old_pix;
      logic [bwfc_pkg::WidthW-1:0]  x;
      logic [bwfc_pkg::HeightW-1:0] y;
      bit                           at_end;
      at_end = 0;
      if (b.action) begin
        // Blank: drop the stored field and any field in progress
        stored_valid = 0;
        end_field();
        run.push_back(wr(bwfc_pkg::KIND_BLANK, '0, '0, '0, '0, '0));
      end else begin
        if (!in_field) begin
          in_field   = 1;
          col        = '0;
          row        = '0;
          field_err  = 0;
          weave_mode = weave_match(b);
        end
        if (!header_ok(b) || col >= b.fw || row >= b.fh) begin
          field_err = 1;
        end else begin
          x = col;
          y = row;
          if (!b.il) begin
            run.push_back(wr(bwfc_pkg::KIND_PIXEL, x, {1'b0, y}, b.fw, {1'b0, b.fh},
                             b.pix));
          end else begin
            // Weave pairs the pixel with the stored one; bob doubles it
            old_pix = weave_mode ? fstore[store_key(stored_bank, x, y, b.fw)] : b.pix;
            if (weave_mode) n_weave += 2;
            run.push_back(wr(bwfc_pkg::KIND_PIXEL, x, {y, 1'b0}, b.fw, {b.fh, 1'b0},
                             b.par[0] ? old_pix : b.pix));
            run.push_back(wr(bwfc_pkg::KIND_PIXEL, x, {y, 1'b1}, b.fw, {b.fh, 1'b0},
                             b.par[0] ? b.pix : old_pix));
            fstore[store_key(!stored_bank, x, y, b.fw)] = b.pix;
          end
          at_end = (x == b.fw - 1'b1) && (y == b.fh - 1'b1);
          col = col + 1'b1;
          if (col == b.fw) begin
            col = '0;
            row = row + 1'b1;
          end
        end
        // Close the field: keep it only when clean and complete
        if (b.last) begin
          if (!field_err && at_end) begin
            if (b.il) begin
              stored_bank  = !stored_bank;
              stored_valid = 1;
              stored_w     = b.fw;
              stored_h     = b.fh;
              stored_il    = 1;
              stored_par   = b.par[0];
            end else begin
              stored_valid = 0;
            end
            run.push_back(wr(bwfc_pkg::KIND_DONE, '0, '0, b.fw,
                             b.il ? {b.fh, 1'b0} : {1'b0, b.fh}, '0));
            n_done++;
          end else begin
            run.push_back(wr(bwfc_pkg::KIND_REJECT, '0, '0, '0, '0, '0));
            n_reject++;
          end
          end_field();
        end
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) frame_wr_q.push_back(run[i]);
    endfunction

    function void compare(string name, longint unsigned expv, longint unsigned actv);
      if (expv != actv) begin
        if (errors < 60) $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
        errors++;
      end
    endfunction

    // Check one output beat against the oldest expected result
    function void check_result(logic [bwfc_pkg::OutDataW-1:0] d, logic [1:0] k, logic l);
      frame_wr_t e;
      if (frame_wr_q.size() == 0) begin
        if (errors < 60) $error("unexpected result: kind %0d, tdata %h", k, d);
        errors++;
        return;
      end
      e = frame_wr_q.pop_front();
      n_checked++;
      compare("kind", e.kind, k);
      compare("out_x", e.x, d[9:0]);
      compare("out_y", e.y, d[19:10]);
      compare("frame_width", e.fw, d[29:20]);
      compare("frame_height", e.fh, d[39:30]);
      compare("out_pixel", e.pix, d[71:40]);
      compare("last_of_run", e.last, l);
    endfunction

    function int pending();
      return frame_wr_q.size();
    endfunction
  endclass

endpackage

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the bob/weave field composer.
// ----------------------------------------------------------------------------
// Feeds pixel beats of progressive and interlaced fields, clean and broken,
// plus blanks and noise, and checks every output beat in order against the
// frame-write scoreboard. Both sides idle at random in the first two random
// phases, and the receiver once holds off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 300;
  localparam int PhaseItems  = 32;

  localparam int unsigned WidthW   = bwfc_pkg::WidthW;
  localparam int unsigned HeightW  = bwfc_pkg::HeightW;
  localparam int unsigned ParityW  = bwfc_pkg::ParityW;
  localparam int unsigned InDataW  = bwfc_pkg::InDataW;
  localparam int unsigned OutDataW = bwfc_pkg::OutDataW;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                s_axis_tuser_i  = 1'b0;
  logic                s_axis_tlast_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;

  bwfc_tb_pkg::frame_scoreboard sb = new();

  int tx_idle_pct = 33;
  int rx_idle_pct = 75;
  int hold_req    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int n_cycles    = 0;
  int n_beats     = 0;
  int n_fields    = 0;
  logic [WidthW-1:0]  last_w   = 10'd2;
  logic [HeightW-1:0] last_h   = 9'd1;
  logic               last_par = 1'b0;

  bob_weave_field_composer_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen       <= hold_req;
      hold_left       <= HoldCycles;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= (int'($urandom_range(99)) >= rx_idle_pct);
    end
  end

  // Check every output beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
  end

  // Bound the run
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic bwfc_tb_pkg::pix_beat_t mk_beat(logic [WidthW-1:0] w,
                                                     logic [HeightW-1:0] h,
                                                     logic [ParityW-1:0] par,
                                                     logic il, logic last);
    bwfc_tb_pkg::pix_beat_t b;
    b.action = 1'b0;
    b.fw     = w;
    b.fh     = h;
    b.par    = par;
    b.il     = il;
    b.pix    = $urandom;
    b.last   = last;
    return b;
  endfunction

  function automatic bwfc_tb_pkg::pix_beat_t noise_beat();
    bwfc_tb_pkg::pix_beat_t b;
    b.action = ($urandom_range(7) == 0);
    b.fw     = WidthW'($urandom);
    b.fh     = HeightW'($urandom);
    b.par    = ParityW'($urandom);
    b.il     = 1'($urandom);
    b.pix    = $urandom;
    b.last   = 1'($urandom);
    return b;
  endfunction

  function automatic bwfc_tb_pkg::pix_beat_t spoil_header(bwfc_tb_pkg::pix_beat_t b);
    case ($urandom_range(4))
      0:       b.fw  = '0;
      1:       b.fh  = '0;
      2:       b.fw  = WidthW'($urandom_range(641, 1023));
      3:       b.fh  = HeightW'($urandom_range(481, 511));
      default: b.par = ParityW'($urandom_range(2, 3));
    endcase
    return b;
  endfunction

  // Offer one beat, hold it until taken, then note it
  task automatic send_beat(input bwfc_tb_pkg::pix_beat_t b);
    int gap;
    // Keep a weave away from words the stored field never wrote
    if (sb.reads_unwritten(b)) b.il = 1'b0;
    gap = (int'($urandom_range(99)) < tx_idle_pct) ? int'($urandom_range(1, 4)) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, b.pix, b.il, b.par, b.fh, b.fw};
    s_axis_tuser_i  <= b.action;
    s_axis_tlast_i  <= b.last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_beat(b);
    n_beats++;
  endtask

  // Send one field in raster order, optionally broken
  task automatic send_field(logic il, logic [ParityW-1:0] par, logic [WidthW-1:0] w,
                            logic [HeightW-1:0] h, bwfc_tb_pkg::flaw_e flaw);
    bwfc_tb_pkg::pix_beat_t b;
    int                     npix, cut;
    npix = int'(w) * int'(h);
    if (flaw == bwfc_tb_pkg::FLAW_SHORT && npix < 2) flaw = bwfc_tb_pkg::FLAW_LONG;
    if (flaw == bwfc_tb_pkg::FLAW_SHORT) npix = npix - 1;
    if (flaw == bwfc_tb_pkg::FLAW_LONG) npix = npix + int'($urandom_range(1, 2));
    cut = $urandom_range(npix - 1);
    n_fields++;
    for (int k = 0; k < npix; k++) begin
      b = mk_beat(w, h, par, il, k == npix - 1);
      if (k == cut) begin
        case (flaw)
          bwfc_tb_pkg::FLAW_BADHDR: b = spoil_header(b);
          bwfc_tb_pkg::FLAW_RESIZE: begin
            b.fw = b.fw + 1'b1;
            b.il = 1'($urandom);
          end
          bwfc_tb_pkg::FLAW_BLANK: begin
            b.action = 1'b1;
            send_beat(b);
            return;
          end
          default: ;
        endcase
      end
      send_beat(b);
    end
    if (flaw == bwfc_tb_pkg::FLAW_NONE && il) begin
      last_w   = w;
      last_h   = h;
      last_par = par[0];
    end
  endtask

  // Mostly clean fields, often the stored size with the other parity
  task automatic random_traffic(int n_items);
    int                 stop, pick;
    logic               il;
    logic [WidthW-1:0]  w;
    logic [HeightW-1:0] h;
    logic [ParityW-1:0] par;
    bwfc_tb_pkg::flaw_e flaw;
    stop = n_beats + n_items;
    while (n_beats < stop) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_beat(noise_beat());
      end else begin
        flaw = (pick < 35) ? bwfc_tb_pkg::flaw_e'($urandom_range(1, 5)) :
                             bwfc_tb_pkg::FLAW_NONE;
        il   = ($urandom_range(3) != 0);
        if (il && $urandom_range(1)) begin
          w   = last_w;
          h   = last_h;
          par = {1'b0, ~last_par};
        end else begin
          w   = WidthW'($urandom_range(1, 4));
          h   = HeightW'($urandom_range(1, 3));
          par = ParityW'($urandom_range(1));
        end
        send_field(il, par, w, h, flaw);
      end
    end
  endtask

  initial begin
    bwfc_tb_pkg::pix_beat_t b;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: blank out of reset, extreme pixel words
    b = mk_beat('0, '0, '0, 1'b0, 1'b0);
    b.action = 1'b1;
    send_beat(b);
    b = mk_beat(10'd1, 9'd1, 2'd0, 1'b0, 1'b1);
    b.pix = '0;
    send_beat(b);
    b = mk_beat(10'd1, 9'd1, 2'd1, 1'b0, 1'b1);
    b.pix = '1;
    send_beat(b);
    // Bob, weave, then bob again on a repeated parity
    send_field(1'b1, 2'd0, 10'd2, 9'd1, bwfc_tb_pkg::FLAW_NONE);
    send_field(1'b1, 2'd1, 10'd2, 9'd1, bwfc_tb_pkg::FLAW_NONE);
    send_field(1'b1, 2'd1, 10'd2, 9'd1, bwfc_tb_pkg::FLAW_NONE);
    // Woven field whose second pixel turns progressive
    send_beat(mk_beat(10'd2, 9'd1, 2'd0, 1'b1, 1'b0));
    send_beat(mk_beat(10'd2, 9'd1, 2'd0, 1'b0, 1'b1));
    // Bad headers, each closing its own field
    send_beat(mk_beat(10'd0, 9'd1, 2'd0, 1'b1, 1'b1));
    send_beat(mk_beat(10'd1, 9'd0, 2'd0, 1'b1, 1'b1));
    send_beat(mk_beat(10'd1023, 9'd1, 2'd0, 1'b0, 1'b1));
    send_beat(mk_beat(10'd1, 9'd511, 2'd0, 1'b1, 1'b1));
    send_beat(mk_beat(10'd1, 9'd1, 2'd3, 1'b1, 1'b1));
    // Too many pixels, too few, and a blank mid-field
    send_field(1'b0, 2'd0, 10'd1, 9'd1, bwfc_tb_pkg::FLAW_LONG);
    send_field(1'b1, 2'd0, 10'd2, 9'd2, bwfc_tb_pkg::FLAW_SHORT);
    send_field(1'b1, 2'd1, 10'd2, 9'd1, bwfc_tb_pkg::FLAW_BLANK);
    // Largest legal header, cut short after one pixel
    send_beat(mk_beat(10'd640, 9'd480, 2'd0, 1'b1, 1'b1));
    send_beat(mk_beat(10'd640, 9'd480, 2'd1, 1'b0, 1'b1));

    // Random phases: sender idles less than receiver, then the reverse
    random_traffic(PhaseItems);
    tx_idle_pct = 75;
    rx_idle_pct = 33;
    random_traffic(PhaseItems);

    // No idling; stall the receiver long while beats keep coming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = hold_req + 1;
    random_traffic(PhaseItems);
    s_axis_tvalid_i <= 1'b0;

    // Drain, then allow for stray results
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d beats in %0d fields plus noise; %0d results checked.",
             n_beats, n_fields, sb.n_checked);
    $display("Frames completed %0d, fields rejected %0d, woven writes %0d.",
             sb.n_done, sb.n_reject, sb.n_weave);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* bob_weave_field_composer_top.f */
src/bwfc_pkg.sv
src/bwfc_field_store.sv
src/bwfc_field_ctrl.sv
src/bwfc_result_seq.sv
src/bob_weave_field_composer_top.sv
src/bwfc_checker.sv
bench/bwfc_tb_pkg.sv
bench/tb_top.sv
